// ----- rtl/core/assert_macros.svh -----
// ------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL files.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, off while reset is held.
`define ASSERT_CLK(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");

// Next-cycle implication.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// ----- rtl/core/bbpm_pkg.sv -----
// ------------------------------------------------------------------------
// bbpm_pkg
// Types, field widths and helpers for the button binding match table.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbpm_pkg;

	localparam int FUNC_W   = 1;
	localparam int BUTTON_W = 5;
	localparam int MASK_W   = 32;
	localparam int CMD_W    = 10;
	localparam int BITS_W   = 6;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_WRITE,
		ST_LINK,
		ST_DONE
	} bbpm_state_t;

	typedef struct packed {
		logic start;
		logic step;
		logic set_found;
		logic set_full;
		logic write_entry;
		logic write_link;
		logic load_out;
	} bbpm_cmd_t;

	typedef struct packed {
		logic in_range;
		logic is_lookup;
		logic table_full;
		logic cur_ok;
		logic subset_hit;
		logic go_deeper;
		logic prev_zero;
		logic out_free;
	} bbpm_status_t;

	function automatic logic [BITS_W-1:0] popcount32(input logic [MASK_W-1:0] v);
		logic [BITS_W-1:0] c;
		c = '0;
		for (int i = 0; i < MASK_W; i++) begin
			c = c + BITS_W'(v[i]);
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/bbpm_in_if.sv -----
// ------------------------------------------------------------------------
// bbpm_in_if
// Request channel: insert or lookup item with valid/ready handshake.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bbpm_in_if;
	import bbpm_pkg::*;

	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [BUTTON_W-1:0] button;
	logic [MASK_W-1:0]   modifier_mask;
	logic [CMD_W-1:0]    command;

	modport source (output valid, func, button, modifier_mask, command, input ready);
	modport sink   (input valid, func, button, modifier_mask, command, output ready);
endinterface

// ----- rtl/core/bbpm_out_if.sv -----
// ------------------------------------------------------------------------
// bbpm_out_if
// Response channel: matched command and table-full flag.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bbpm_out_if;
	import bbpm_pkg::*;

	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] found_command;
	logic             table_full;

	modport source (output valid, found_command, table_full, input ready);
	modport sink   (input valid, found_command, table_full, output ready);
endinterface

// ----- rtl/core/bbpm_ctrl.sv -----
// ------------------------------------------------------------------------
// bbpm_ctrl
// Sequencer for capture, list walk, entry write, relink and response.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbpm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  bbpm_pkg::bbpm_status_t sts,
	output bbpm_pkg::bbpm_cmd_t    cmd
);
	import bbpm_pkg::*;

	bbpm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_WALK;
				end
			end
			ST_WALK: begin
				// read data in this state belongs to the current link
				priority if (!sts.in_range) begin
					state_d = ST_DONE;
				end else if (sts.is_lookup) begin
					priority if (!sts.cur_ok) begin
						state_d = ST_DONE;
					end else if (sts.subset_hit) begin
						cmd.set_found = 1'b1;
						state_d       = ST_DONE;
					end else begin
						cmd.step = 1'b1;
					end
				end else begin
					priority if (sts.table_full) begin
						cmd.set_full = 1'b1;
						state_d      = ST_DONE;
					end else if (sts.cur_ok && sts.go_deeper) begin
						cmd.step = 1'b1;
					end else begin
						state_d = ST_WRITE;
					end
				end
			end
			ST_WRITE: begin
				cmd.write_entry = 1'b1;
				state_d = sts.prev_zero ? ST_DONE : ST_LINK;
			end
			ST_LINK: begin
				cmd.write_link = 1'b1;
				state_d        = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

// ----- rtl/core/bbpm_datapath.sv -----
// ------------------------------------------------------------------------
// bbpm_datapath
// Head table, entry memories, walk pointers and response register.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbpm_datapath #(
	parameter int BUTTONS = 32,
	parameter int ENTRIES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bbpm_pkg::bbpm_cmd_t           cmd,
	output bbpm_pkg::bbpm_status_t        sts,
	input  logic [bbpm_pkg::FUNC_W-1:0]   in_func,
	input  logic [bbpm_pkg::BUTTON_W-1:0] in_button,
	input  logic [bbpm_pkg::MASK_W-1:0]   in_mask,
	input  logic [bbpm_pkg::CMD_W-1:0]    in_command,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [bbpm_pkg::CMD_W-1:0]    out_found_command,
	output logic                          out_table_full
);
	import bbpm_pkg::*;

	// links and counts hold index+1, so they need room for ENTRIES itself
	localparam int LW = $clog2(ENTRIES + 1);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int BW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

	logic [FUNC_W-1:0]   func_q;
	logic [BUTTON_W-1:0] button_q;
	logic [MASK_W-1:0]   mask_q;
	logic [CMD_W-1:0]    command_q;
	logic [BITS_W-1:0]   cb_q;

	logic [LW-1:0] cur_q, prev_q, steps_q, count_q;
	logic [LW-1:0] head_q [BUTTONS];

	logic [CMD_W-1:0] found_q;
	logic             full_q;
	logic             out_valid_q;
	logic [CMD_W-1:0] out_found_q;
	logic             out_full_q;

	logic [MASK_W-1:0] mem_mask [ENTRIES];
	logic [CMD_W-1:0]  mem_cmd  [ENTRIES];
	logic [BITS_W-1:0] mem_bits [ENTRIES];
	logic [LW-1:0]     mem_next [ENTRIES];

	logic [MASK_W-1:0] rd_mask_q;
	logic [CMD_W-1:0]  rd_cmd_q;
	logic [BITS_W-1:0] rd_bits_q;
	logic [LW-1:0]     rd_next_q;

	logic          load_cur;
	logic [LW-1:0] cur_d, cur_m1, prev_m1, count_inc;
	logic [IW-1:0] rd_addr, wr_idx, link_idx;
	logic          cur_link_ok;

	assign load_cur  = cmd.start | cmd.step;
	assign cur_d     = cmd.start ? head_q[in_button[BW-1:0]] : rd_next_q;
	assign cur_m1    = cur_d - LW'(1);
	assign rd_addr   = cur_m1[IW-1:0];
	assign prev_m1   = prev_q - LW'(1);
	assign link_idx  = prev_m1[IW-1:0];
	assign wr_idx    = count_q[IW-1:0];
	assign count_inc = count_q + LW'(1);

	assign cur_link_ok = (cur_q != '0) && (cur_q <= LW'(ENTRIES));

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			func_q    <= in_func;
			button_q  <= in_button;
			mask_q    <= in_mask;
			command_q <= in_command;
			cb_q      <= popcount32(in_mask);
		end
	end

	// walk pointers, fill count, list heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			prev_q  <= '0;
			steps_q <= '0;
			count_q <= '0;
			for (int b = 0; b < BUTTONS; b++) begin
				head_q[b] <= '0;
			end
		end else begin
			if (cmd.start) begin
				prev_q  <= '0;
				steps_q <= '0;
			end else if (cmd.step) begin
				prev_q  <= cur_q;
				steps_q <= steps_q + LW'(1);
			end
			if (load_cur) begin
				cur_q <= cur_d;
			end
			if (cmd.write_entry) begin
				count_q <= count_inc;
				if (prev_q == '0) begin
					head_q[button_q[BW-1:0]] <= count_inc;
				end
			end
		end
	end

	// entry payload memory, read at the link being loaded
	always_ff @(posedge clk) begin
		if (cmd.write_entry) begin
			mem_mask[wr_idx] <= mask_q;
			mem_cmd[wr_idx]  <= command_q;
			mem_bits[wr_idx] <= cb_q;
		end
		if (load_cur) begin
			rd_mask_q <= mem_mask[rd_addr];
			rd_cmd_q  <= mem_cmd[rd_addr];
			rd_bits_q <= mem_bits[rd_addr];
		end
	end

	// next-link memory; predecessor relink happens in the cycle after the entry write,
	// when count_q already holds the new entry's index+1
	always_ff @(posedge clk) begin
		if (cmd.write_entry) begin
			mem_next[wr_idx] <= cur_link_ok ? cur_q : '0;
		end else if (cmd.write_link) begin
			mem_next[link_idx] <= count_q;
		end
		if (load_cur) begin
			rd_next_q <= mem_next[rd_addr];
		end
	end

	// per-item result
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			found_q <= '0;
			full_q  <= 1'b0;
		end else begin
			if (cmd.set_found) begin
				found_q <= rd_cmd_q;
			end
			if (cmd.set_full) begin
				full_q <= 1'b1;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_found_q <= found_q;
			out_full_q  <= full_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_found_command = out_found_q;
	assign out_table_full    = out_full_q;

	always_comb begin
		sts.in_range   = {1'b0, button_q} < (BUTTON_W + 1)'(BUTTONS);
		sts.is_lookup  = (func_q == FUNC_LOOKUP);
		sts.table_full = (count_q >= LW'(ENTRIES));
		sts.cur_ok     = cur_link_ok && (steps_q < LW'(ENTRIES));
		sts.subset_hit = ((mask_q & rd_mask_q) == rd_mask_q);
		sts.go_deeper  = (cb_q < rd_bits_q);
		sts.prev_zero  = (prev_q == '0);
		sts.out_free   = !out_valid_q || out_ready;
	end
endmodule

// ----- rtl/core/button_binding_priority_match.sv -----
// ------------------------------------------------------------------------
// button_binding_priority_match
// Button binding table: per-button lists sorted by modifier count, with
// most-specific subset lookup.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   func, button, modifier_mask, command
//   rsp      out  valid/ready   found_command, table_full
//
// One item at a time; the walk reads one list entry per cycle. A lookup stops
// at the first entry whose mask is a subset of the item's mask, or at the end
// of the list; an insert walks past entries with more modifier bits, writes
// the new entry and then, when it links behind an entry, relinks it.
// req is ready again once the result is registered; a stalled rsp holds the
// controller in DONE. Reset empties all lists; entry memories are not cleared.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module button_binding_priority_match #(
	parameter int BUTTONS = 32,
	parameter int ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	bbpm_in_if.sink     req,
	bbpm_out_if.source  rsp
);
	import bbpm_pkg::*;

	bbpm_cmd_t    cmd;
	bbpm_status_t sts;

	bbpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bbpm_datapath #(
		.BUTTONS (BUTTONS),
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.in_func           (req.func),
		.in_button         (req.button),
		.in_mask           (req.modifier_mask),
		.in_command        (req.command),
		.out_ready         (rsp.ready),
		.out_valid         (rsp.valid),
		.out_found_command (rsp.found_command),
		.out_table_full    (rsp.table_full)
	);

	`ASSERT_IMPLIES(a_step_on_live_link, clk, arst_n, cmd.step, sts.cur_ok)
	`ASSERT_IMPLIES(a_write_only_with_room, clk, arst_n, cmd.write_entry,
		sts.in_range && !sts.table_full && !sts.is_lookup)
	`ASSERT_IMPLIES(a_relink_has_prev, clk, arst_n, cmd.write_link, !sts.prev_zero)
	`ASSERT_IMPLIES(a_load_out_when_free, clk, arst_n, cmd.load_out, sts.out_free)
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready)
endmodule
